// ----- src/bks_pkg.sv -----
// Package for the bottom-K sketch merge block: sizes, field types and opcodes.
// Used by the channel interfaces, the divider, the top level and its checker.
`timescale 1ns / 1ps
package bks_pkg;
	localparam int SLOTS       = 1024;
	localparam int K           = 64;
	localparam int WEIGHT_BITS = 20;
	localparam int SCALE_W     = 40;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int IDX_W       = $clog2(K);
	localparam int CNT_W       = $clog2(K + 1);
	localparam int ADDR_W      = SLOT_W + IDX_W;
	localparam int DIVISOR_W   = WEIGHT_BITS + 1;
	localparam int QCNT_W      = $clog2(SCALE_W + 1);

	typedef logic [WEIGHT_BITS-1:0] weight_t;
	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [CNT_W-1:0]       count_t;
	typedef logic [SCALE_W-1:0]     scale_t;

	localparam scale_t SCALE_RESET = SCALE_W'(60000000);
	localparam count_t K_COUNT     = CNT_W'(K);

	typedef enum logic {
		OP_INIT  = 1'b0,
		OP_MERGE = 1'b1
	} op_t;
endpackage

// ----- src/bks_if.sv -----
// Valid/ready channel interfaces for the request and response items.
// Depends on bks_pkg for the field types.
`timescale 1ns / 1ps
interface bks_req_if import bks_pkg::*; ();
	logic    valid;
	logic    ready;
	op_t     opcode;
	slot_t   source_a;
	slot_t   source_b;
	slot_t   dest_slot;
	weight_t init_weight;

	modport source (output valid, opcode, source_a, source_b, dest_slot, init_weight,
		input ready);
	modport sink (input valid, opcode, source_a, source_b, dest_slot, init_weight,
		output ready);
	modport mon (input valid, ready, opcode, source_a, source_b, dest_slot, init_weight);
endinterface

interface bks_rsp_if import bks_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t entry_count;
	logic   sketch_full;
	scale_t estimate;

	modport source (output valid, entry_count, sketch_full, estimate, input ready);
	modport sink (input valid, entry_count, sketch_full, estimate, output ready);
	modport mon (input valid, ready, entry_count, sketch_full, estimate);
endinterface

// ----- src/bks_div.sv -----
// Restoring divider, one quotient bit per cycle, for the sketch estimate.
// Depends on bks_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
module bks_div import bks_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  scale_t               dividend,
	input  logic [DIVISOR_W-1:0] divisor,
	output logic                 done,
	output scale_t               quotient
);
	logic                 busy_q;
	logic                 done_q;
	logic [QCNT_W-1:0]    cnt_q;
	scale_t               q_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] d_q;
	logic [DIVISOR_W:0]   rem_sh;
	logic [DIVISOR_W:0]   rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, q_q[SCALE_W-1]};
	assign rem_sub = rem_sh - {1'b0, d_q};
	assign ge      = rem_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(SCALE_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
			q_q   <= {q_q[SCALE_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule

// ----- src/bottom_k_sketch_merge.sv -----
// Top level of the bottom-K sketch store: sequencer, sketch memories and estimate.
// Depends on bks_pkg, the channel interfaces in bks_if and the divider bks_div.
`timescale 1ns / 1ps
// After reset the block clears its 1024 entry counts, one per cycle, and takes no item
// while it clears them. For a merge item, each source sketch is first copied into a local
// buffer through the single weight memory port, and then the merge writes one kept entry
// per cycle. A full result then goes through the bit-serial divide. One item is in work
// at a time. The response register lets the next item enter while a finished item waits.
// A finished item stays in the sequencer for as long as an earlier item is held in that
// register.
module bottom_k_sketch_merge import bks_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bks_req_if.sink       req,
	bks_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  scale_t        cfg_wdata
);
	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_INIT, ST_CNT_A, ST_CNT_B, ST_CNT_C,
		ST_COPY, ST_PRE, ST_MERGE, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
	} state_t;

	state_t   state_q;
	scale_t   scale_q;
	slot_t    clr_q;
	slot_t    sa_q, sb_q, sd_q;
	weight_t  iw_q;
	count_t   na_q, nb_q, nd_q, ia_q, ib_q, ptr_q;
	logic     sel_b_q;
	logic     rdv_s1;
	logic [IDX_W-1:0] rdi_s1;
	weight_t  last_q;
	scale_t   est_q;
	logic     rsp_valid_q;
	count_t   rsp_cnt_q;
	logic     rsp_full_q;
	scale_t   rsp_est_q;

	weight_t  weights [SLOTS*K];
	count_t   counts [SLOTS];
	weight_t  bufa [K];
	weight_t  bufb [K];
	weight_t  mem_rd_q;
	count_t   cnt_rd_q;
	weight_t  bufa_rd_q, bufb_rd_q;

	logic     has_a, has_b, room, take_a, take_b, step;
	count_t   ia_d, ib_d, cp_n;
	slot_t    cp_slot;
	logic     cp_issue;
	logic [ADDR_W-1:0] mem_addr;
	logic     mem_we;
	weight_t  mem_wdata;
	slot_t    cnt_raddr, cnt_waddr;
	logic     cnt_we;
	count_t   cnt_wdata;
	logic     div_start, div_done;
	scale_t   div_q;

	assign has_a  = ia_q < na_q;
	assign has_b  = ib_q < nb_q;
	assign room   = nd_q < K_COUNT;
	assign take_a = has_a && (!has_b || bufa_rd_q <= bufb_rd_q);
	assign take_b = has_b && (!has_a || bufb_rd_q <= bufa_rd_q);
	assign step   = (state_q == ST_MERGE) && room && (has_a || has_b);
	assign ia_d   = ia_q + CNT_W'(step && take_a);
	assign ib_d   = ib_q + CNT_W'(step && take_b);

	assign cp_n     = sel_b_q ? nb_q : na_q;
	assign cp_slot  = sel_b_q ? sb_q : sa_q;
	assign cp_issue = (state_q == ST_COPY) && (ptr_q < cp_n);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = take_a ? bufa_rd_q : bufb_rd_q;
		mem_addr  = {cp_slot, ptr_q[IDX_W-1:0]};
		if (state_q == ST_INIT) begin
			mem_we    = 1'b1;
			mem_wdata = iw_q;
			mem_addr  = {sd_q, IDX_W'(0)};
		end else if (state_q == ST_MERGE) begin
			mem_we   = step;
			mem_addr = {sd_q, nd_q[IDX_W-1:0]};
		end
	end

	always_comb begin
		cnt_raddr = (state_q == ST_CNT_A) ? sa_q : sb_q;
		cnt_we    = 1'b0;
		cnt_waddr = sd_q;
		cnt_wdata = nd_q;
		if (state_q == ST_CLEAR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_q;
			cnt_wdata = '0;
		end else if (state_q == ST_INIT) begin
			cnt_we    = 1'b1;
			cnt_wdata = CNT_W'(1);
		end else if (state_q == ST_MERGE && !step) begin
			cnt_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			weights[mem_addr] <= mem_wdata;
		end
		mem_rd_q <= weights[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			counts[cnt_waddr] <= cnt_wdata;
		end
		cnt_rd_q <= counts[cnt_raddr];
	end

	// Buffers hold the source sketches so the destination may overwrite either source.
	always_ff @(posedge clk) begin
		if (rdv_s1 && !sel_b_q) begin
			bufa[rdi_s1] <= mem_rd_q;
		end
		if (rdv_s1 && sel_b_q) begin
			bufb[rdi_s1] <= mem_rd_q;
		end
		bufa_rd_q <= bufa[ia_d[IDX_W-1:0]];
		bufb_rd_q <= bufb[ib_d[IDX_W-1:0]];
	end

	assign div_start = (state_q == ST_DIV_GO) && (nd_q == K_COUNT);

	bks_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (scale_q),
		.divisor  ({1'b0, last_q} + DIVISOR_W'(1)),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			sel_b_q     <= 1'b0;
			rdv_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// In ST_DONE the response register is either reloaded or still held.
			if (rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SLOT_W'(SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						sa_q    <= req.source_a;
						sb_q    <= req.source_b;
						sd_q    <= req.dest_slot;
						iw_q    <= req.init_weight;
						ia_q    <= '0;
						ib_q    <= '0;
						nd_q    <= '0;
						ptr_q   <= '0;
						sel_b_q <= 1'b0;
						rdv_s1  <= 1'b0;
						state_q <= (req.opcode == OP_MERGE) ? ST_CNT_A : ST_INIT;
					end
				end
				ST_INIT: begin
					nd_q    <= CNT_W'(1);
					last_q  <= iw_q;
					state_q <= ST_DIV_GO;
				end
				ST_CNT_A: state_q <= ST_CNT_B;
				ST_CNT_B: begin
					na_q    <= cnt_rd_q;
					state_q <= ST_CNT_C;
				end
				ST_CNT_C: begin
					nb_q    <= cnt_rd_q;
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					rdv_s1 <= cp_issue;
					rdi_s1 <= ptr_q[IDX_W-1:0];
					if (cp_issue) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!rdv_s1) begin
						if (sel_b_q) begin
							state_q <= ST_PRE;
						end else begin
							sel_b_q <= 1'b1;
							ptr_q   <= '0;
						end
					end
				end
				ST_PRE: state_q <= ST_MERGE;
				ST_MERGE: begin
					if (step) begin
						ia_q   <= ia_d;
						ib_q   <= ib_d;
						nd_q   <= nd_q + 1'b1;
						last_q <= mem_wdata;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: begin
					est_q   <= SCALE_W'(nd_q);
					state_q <= (nd_q == K_COUNT) ? ST_DIV_WAIT : ST_DONE;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						est_q   <= div_q;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_cnt_q   <= nd_q;
						rsp_full_q  <= (nd_q == K_COUNT);
						rsp_est_q   <= est_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.entry_count = rsp_cnt_q;
	assign rsp.sketch_full = rsp_full_q;
	assign rsp.estimate    = rsp_est_q;
endmodule

// ----- src/bks_chk.sv -----
// Port-level checker for the bottom-K sketch merge block, bound to its top level.
// Depends on bks_pkg; it watches the response channel signals of the top level.
`timescale 1ns / 1ps
module bks_chk import bks_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   rsp_valid,
	input logic   rsp_ready,
	input count_t rsp_entry_count,
	input logic   rsp_sketch_full,
	input scale_t rsp_estimate
);
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_sketch_full == (rsp_entry_count == K_COUNT)))
		else $error("full flag disagrees with entry count");

	a_small_est: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_sketch_full) |-> (rsp_estimate == SCALE_W'(rsp_entry_count)))
		else $error("estimate of a partial sketch is not its count");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_entry_count <= K_COUNT))
		else $error("entry count above sketch size");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_estimate)))
		else $error("stalled response item changed");
endmodule

bind bottom_k_sketch_merge bks_chk u_bks_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_entry_count (rsp.entry_count),
	.rsp_sketch_full (rsp.sketch_full),
	.rsp_estimate    (rsp.estimate)
);

// ----- bench/bottom_k_sketch_merge_test.sv -----
// Self-checking bench for bottom_k_sketch_merge: random init and merge items with a
// behavioral sketch store as predictor. Depends on bks_pkg, bks_if and the block's RTL.
`timescale 1ns / 1ps
module bottom_k_sketch_merge_test;
	import bks_pkg::*;

	typedef struct packed {
		op_t     opcode;
		slot_t   source_a;
		slot_t   source_b;
		slot_t   dest_slot;
		weight_t init_weight;
	} sketch_op_t;

	typedef struct packed {
		count_t entry_count;
		logic   sketch_full;
		scale_t estimate;
	} sketch_report_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   cfg_we = 1'b0;
	scale_t cfg_wdata = '0;
	logic   failed = 1'b0;

	bks_req_if req ();
	bks_rsp_if rsp ();

	bottom_k_sketch_merge dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// Predictor state.
	weight_t        store_weights [SLOTS][K];
	int unsigned    store_counts [SLOTS];
	scale_t         scale_model;
	sketch_op_t     pending_ops [$];
	sketch_report_t expected_reports [$];
	int unsigned    send_gap = 0;
	int unsigned    stall_left = 0;
	int unsigned    slot_pool [$];

	function automatic sketch_report_t predict_report(sketch_op_t op);
		weight_t     bufa [K];
		weight_t     bufb [K];
		int unsigned na;
		int unsigned nb;
		int unsigned ia;
		int unsigned ib;
		int unsigned nd;
		sketch_report_t r;
		if (op.opcode == OP_INIT) begin
			store_weights[op.dest_slot][0] = op.init_weight;
			store_counts[op.dest_slot] = 1;
		end else begin
			na = store_counts[op.source_a];
			nb = store_counts[op.source_b];
			for (int i = 0; i < K; i++) begin
				bufa[i] = store_weights[op.source_a][i];
				bufb[i] = store_weights[op.source_b][i];
			end
			ia = 0; ib = 0; nd = 0;
			while (nd < K && (ia < na || ib < nb)) begin
				if (ia < na && ib < nb && bufa[ia] == bufb[ib]) begin
					store_weights[op.dest_slot][nd] = bufa[ia];
					nd++; ia++; ib++;
				end else if (ib >= nb || (ia < na && bufa[ia] < bufb[ib])) begin
					store_weights[op.dest_slot][nd] = bufa[ia];
					nd++; ia++;
				end else begin
					store_weights[op.dest_slot][nd] = bufb[ib];
					nd++; ib++;
				end
			end
			store_counts[op.dest_slot] = nd;
		end
		r.entry_count = count_t'(store_counts[op.dest_slot]);
		r.sketch_full = (store_counts[op.dest_slot] == K);
		if (r.sketch_full)
			r.estimate = scale_model /
				({20'd0, store_weights[op.dest_slot][K-1]} + 40'd1);
		else
			r.estimate = scale_t'(store_counts[op.dest_slot]);
		return r;
	endfunction

	function automatic int unsigned random_gap();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// Driver: takes the head of the pending queue, predicts it when it is accepted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.opcode <= OP_INIT;
			req.source_a <= '0;
			req.source_b <= '0;
			req.dest_slot <= '0;
			req.init_weight <= '0;
		end else begin
			if (req.valid && req.ready) begin
				expected_reports.push_back(predict_report({req.opcode, req.source_a,
					req.source_b, req.dest_slot, req.init_weight}));
				void'(pending_ops.pop_front());
				send_gap = random_gap();
			end
			if (!(req.valid && !req.ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					req.valid <= 1'b0;
				end else if (pending_ops.size() > 0) begin
					req.valid <= 1'b1;
					req.opcode <= pending_ops[0].opcode;
					req.source_a <= pending_ops[0].source_a;
					req.source_b <= pending_ops[0].source_b;
					req.dest_slot <= pending_ops[0].dest_slot;
					req.init_weight <= pending_ops[0].init_weight;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor and response stall.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected item: entry_count %0d", rsp.entry_count);
					failed = 1'b1;
				end else begin
					if (rsp.entry_count !== expected_reports[0].entry_count) begin
						$error("entry_count expected %0d actual %0d",
							expected_reports[0].entry_count, rsp.entry_count);
						failed = 1'b1;
					end
					if (rsp.sketch_full !== expected_reports[0].sketch_full) begin
						$error("sketch_full expected %0d actual %0d",
							expected_reports[0].sketch_full, rsp.sketch_full);
						failed = 1'b1;
					end
					if (rsp.estimate !== expected_reports[0].estimate) begin
						$error("estimate expected %0d actual %0d",
							expected_reports[0].estimate, rsp.estimate);
						failed = 1'b1;
					end
					void'(expected_reports.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
				stall_left = random_gap();
			end
		end
	end

	task automatic queue_op(op_t opc, int unsigned a, int unsigned b, int unsigned d,
		int unsigned w);
		sketch_op_t op;
		op.opcode = opc;
		op.source_a = slot_t'(a);
		op.source_b = slot_t'(b);
		op.dest_slot = slot_t'(d);
		op.init_weight = weight_t'(w);
		pending_ops.push_back(op);
	endtask

	task automatic drain();
		wait (pending_ops.size() == 0 && expected_reports.size() == 0);
		repeat (400) @(posedge clk);
	endtask

	task automatic set_scale(scale_t value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		scale_model = value;
	endtask

	// Fills a slot with up to n, at most K, ascending distinct-ish random weights through init and merge.
	task automatic build_sketch(int unsigned dest, int unsigned n, int unsigned top);
		queue_op(OP_INIT, $urandom, $urandom, dest, $urandom_range(0, top));
		for (int i = 1; i < n; i++) begin
			queue_op(OP_INIT, $urandom, $urandom, 1023, $urandom_range(0, top));
			queue_op(OP_MERGE, dest, 1023, dest, $urandom);
		end
	endtask

	initial begin
		int unsigned sent;
		int unsigned a;
		int unsigned b;
		scale_model = SCALE_RESET;
		for (int i = 0; i < SLOTS; i++) store_counts[i] = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: weight extremes, empty merges, self merge, dest as source.
		queue_op(OP_MERGE, 5, 6, 7, 20'hFFFFF);
		queue_op(OP_INIT, 1023, 1023, 0, 0);
		queue_op(OP_INIT, 0, 0, 1023, 20'hFFFFF);
		queue_op(OP_MERGE, 0, 1023, 1, 0);
		queue_op(OP_MERGE, 1, 1, 1, 0);
		queue_op(OP_MERGE, 1, 0, 1, 20'h55555);
		queue_op(OP_MERGE, 2, 1, 3, 20'hAAAAA);
		queue_op(OP_INIT, 0, 0, 512, 20'h80000);
		queue_op(OP_MERGE, 512, 3, 512, 0);
		build_sketch(10, 70, 20'hFFFFF);
		queue_op(OP_MERGE, 10, 10, 11, 0);
		drain();
		set_scale(40'hFF_FFFF_FFFF);
		build_sketch(20, 66, 200);
		queue_op(OP_MERGE, 20, 10, 20, 0);
		drain();
		set_scale(40'd0);
		queue_op(OP_MERGE, 10, 20, 21, 0);
		drain();
		set_scale(40'd1);
		queue_op(OP_MERGE, 20, 20, 22, 0);
		drain();

		// Random: inits and merges over a small pool of slots, with some merges of random slots, so sketches grow and fill.
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) set_scale(scale_t'({$urandom, $urandom}));
			if (phase == 2) set_scale(SCALE_RESET);
			sent = 0;
			while (sent < 160) begin
				a = $urandom_range(0, 15) * 64 + $urandom_range(0, 3);
				b = $urandom_range(0, 15) * 64 + $urandom_range(0, 3);
				if ($urandom_range(0, 99) < 35)
					queue_op(OP_INIT, $urandom, $urandom, a,
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom);
				else if ($urandom_range(0, 9) == 0)
					queue_op(OP_MERGE, $urandom, $urandom, $urandom, $urandom);
				else
					queue_op(OP_MERGE, a, b, ($urandom_range(0, 2) == 0) ? a : b,
						$urandom);
				sent++;
				wait (pending_ops.size() < 8);
			end
			drain();
		end

		if (!failed)
			$display("bottom_k_sketch_merge regression: pass");
		else
			$display("bottom_k_sketch_merge regression: fail");
		$finish;
	end

	initial begin
		#60ms;
		$display("bottom_k_sketch_merge regression: fail");
		$finish;
	end
endmodule

// ----- bottom_k_sketch_merge.f -----
src/bks_pkg.sv
src/bks_if.sv
src/bks_div.sv
src/bottom_k_sketch_merge.sv
src/bks_chk.sv
bench/bottom_k_sketch_merge_test.sv
